### rtl/ddo_pkg.sv
// Shared types, constants and helper functions of the odometry smoother.
`default_nettype none
package ddo_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);
   localparam int ATAN_IW      = 5;

   // Shared multiply and divide unit widths.
   localparam int MD_AW = 64;
   localparam int MD_BW = 32;
   localparam int MD_DW = 34;
   localparam int MD_CW = $clog2(MD_AW);

   localparam logic [MD_BW-1:0] DEG_Q32     = 32'd74961320;
   localparam logic [MD_AW-1:0] INV2PI_Q32  = 64'd683565276;
   localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032875;

   localparam logic [MD_DW-1:0] TURN_DIV  = MD_DW'(64'd1 << (32 - FRAC_BITS));
   localparam logic [MD_DW-1:0] MS_DIV    = MD_DW'(1000);
   localparam logic [MD_DW-1:0] Q16_DIV   = MD_DW'(64'd1 << 16);
   localparam logic [MD_DW-1:0] STEP_DIV  = 34'd16384000000;
   localparam logic [MD_DW-1:0] FIX_ONE   = MD_DW'(64'd1 << FRAC_BITS);
   localparam logic [MD_DW-1:0] SPEED_DIV = MD_DW'(64'd1000 << FRAC_BITS);

   localparam logic [16:0] MAX_GAIN     = 17'd65536;
   localparam int          REPORT_LIMIT = 30000;

   // Configuration register indexes.
   localparam logic CSR_TICK_PERIOD = 1'b0;
   localparam logic CSR_SMOOTH_GAIN = 1'b1;

   typedef struct packed {
      logic signed [15:0] left_speed_mms;
      logic signed [15:0] right_speed_mms;
      logic signed [11:0] yaw_rate_dps;
   } ddo_req_type;

   typedef struct packed {
      logic signed [31:0] smooth_x_q16;
      logic signed [31:0] smooth_y_q16;
      logic signed [31:0] smooth_heading_q16;
      logic signed [31:0] smooth_speed_q16;
      logic signed [31:0] smooth_turn_q16;
      logic [31:0]        elapsed_ms;
      logic signed [15:0] report_x_dm;
      logic signed [15:0] report_y_dm;
      logic signed [15:0] report_heading_mrad;
      logic [7:0]         report_speed_byte;
   } ddo_rsp_type;

   // Operation handed to the multiply and divide unit:
   // result = sign * ((|a| * |b| + bias) / divisor), or the signed product alone.
   typedef struct packed {
      logic signed [MD_AW-1:0] a;
      logic signed [MD_BW-1:0] b;
      logic [MD_DW-1:0]        divisor;
      logic [MD_DW-1:0]        bias;
      logic                    use_div;
   } ddo_md_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [MD_AW-1:0] result;
   } ddo_md_rsp_type;

   // Arctangent of 2^-i in units of 2^-32 turns.
   function automatic logic [31:0] atan_turns(input logic [ATAN_IW-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] clamp_report(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'(REPORT_LIMIT)) begin
         r = 16'(REPORT_LIMIT);
      end else if (v < -64'(REPORT_LIMIT)) begin
         r = -16'(REPORT_LIMIT);
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/diff_drive_odometry_smoother.sv
// Top level of the differential-drive odometry block with exponential pose smoothing.
//
// One request transfer carries a tick: both wheel speeds and the gyro yaw rate. The block
// integrates heading, then x and y along the cosine and sine of the new heading, advances
// a millisecond counter, runs the exponential smoother and forms the report fields. Each
// tick gives exactly one response transfer.
// All multiplications and divisions are done by one bit-serial multiply and divide unit, one
// multiplier bit and then one quotient bit per cycle, plus a CORDIC that rotates one step per
// cycle. A tick uses up to 16 such operations and the CORDIC pass; the next request is taken
// once the block is back in idle. Configuration registers are written through the csr port;
// the user must write them only while the block is idle, as the block does not enforce it.
// After reset the pose, smoother and counter are zero, the period is 20 ms, the gain 0.35,
// and the first tick loads the smoother directly. A stalled response holds in its output
// register; the block may still take the next request, but finishes it only after the
// waiting response has been taken.
`default_nettype none
module diff_drive_odometry_smoother
   import ddo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ddo_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ddo_rsp_type rsp_data,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_TURN, S_HEAD, S_PHASE, S_CORDIC, S_DX1, S_DX2, S_DY1, S_DY2,
      S_SMX, S_SMY, S_SMH, S_SMS, S_SMT, S_RPX, S_RPY, S_RPH, S_RPS, S_OUT
   } state_type;

   state_type          state_ff;
   logic               issued_ff;
   logic [9:0]         period_ff;
   logic [16:0]        gain_ff;
   ddo_req_type        in_ff;
   logic signed [31:0] speed_ff;
   logic signed [31:0] turn_ff;
   logic signed [31:0] head_ff;
   logic signed [31:0] pose_x_ff;
   logic signed [31:0] pose_y_ff;
   logic signed [31:0] filt_x_ff;
   logic signed [31:0] filt_y_ff;
   logic signed [31:0] filt_h_ff;
   logic signed [31:0] filt_s_ff;
   logic signed [31:0] filt_t_ff;
   logic [31:0]        elapsed_ff;
   logic               primed_ff;
   logic signed [33:0] cx_ff;
   logic signed [33:0] cy_ff;
   logic signed [33:0] cz_ff;
   logic               flip_ff;
   logic [CORDIC_IW-1:0] iter_ff;
   logic signed [63:0] tmp_ff;
   logic signed [15:0] rep_x_ff;
   logic signed [15:0] rep_y_ff;
   logic signed [15:0] rep_h_ff;
   logic [7:0]         rep_sb_ff;
   logic               rsp_valid_ff;
   ddo_rsp_type        rsp_data_ff;

   ddo_md_req_type     md_req;
   ddo_md_rsp_type     md_rsp;
   logic               md_start;
   logic               is_op;

   logic signed [16:0] wheel_sum;
   logic signed [31:0] speed_in;
   logic [16:0]        alpha;
   logic signed [31:0] period32;
   logic signed [33:0] cos_full;
   logic signed [33:0] sin_full;
   logic signed [33:0] cx_shift;
   logic signed [33:0] cy_shift;
   logic signed [33:0] atan_step;
   logic [31:0]        phase;
   logic [31:0]        phase_fold;
   logic signed [63:0] q;
   logic signed [63:0] sb_sum;

   // The forward speed needs only an add and a shift, so it is taken at the request transfer.
   assign wheel_sum = 17'(req_data.left_speed_mms) + 17'(req_data.right_speed_mms);
   assign speed_in  = sat32(64'(wheel_sum) <<< (FRAC_BITS - 1));

   assign alpha    = (gain_ff > MAX_GAIN) ? MAX_GAIN : gain_ff;
   assign period32 = $signed(32'(period_ff));

   assign cos_full = flip_ff ? -cx_ff : cx_ff;
   assign sin_full = flip_ff ? -cy_ff : cy_ff;

   assign cx_shift  = cx_ff >>> iter_ff;
   assign cy_shift  = cy_ff >>> iter_ff;
   assign atan_step = $signed({2'b00, atan_turns(ATAN_IW'(iter_ff))});

   // The product result holds heading times 1/(2 pi); its fraction of a turn is the phase.
   // Phases in the left half plane are turned by half a turn and the result negated.
   assign q          = md_rsp.result;
   assign phase      = q[FRAC_BITS+31:FRAC_BITS];
   assign phase_fold = (phase[31] ^ phase[30]) ? {~phase[31], phase[30:0]} : phase;

   assign sb_sum = q + 64'sd128;

   assign is_op    = !(state_ff inside {S_IDLE, S_CORDIC, S_OUT});
   assign md_start = is_op && !issued_ff;

   // Operands for the shared unit, chosen by the sequencer state.
   always_comb begin
      md_req         = '0;
      md_req.use_div = 1'b1;
      case (state_ff)
         S_TURN: begin
            md_req.a       = $signed(64'(DEG_Q32));
            md_req.b       = 32'(in_ff.yaw_rate_dps);
            md_req.divisor = TURN_DIV;
            md_req.bias    = TURN_DIV >> 1;
         end
         S_HEAD: begin
            md_req.a       = 64'(turn_ff);
            md_req.b       = period32;
            md_req.divisor = MS_DIV;
            md_req.bias    = MS_DIV >> 1;
         end
         S_PHASE: begin
            md_req.a       = $signed(INV2PI_Q32);
            md_req.b       = head_ff;
            md_req.use_div = 1'b0;
         end
         S_DX1, S_DY1: begin
            md_req.a       = 64'(speed_ff);
            md_req.b       = (state_ff == S_DX1) ? cos_full[31:0] : sin_full[31:0];
            md_req.divisor = Q16_DIV;
            md_req.bias    = Q16_DIV >> 1;
         end
         S_DX2, S_DY2: begin
            md_req.a       = tmp_ff;
            md_req.b       = period32;
            md_req.divisor = STEP_DIV;
            md_req.bias    = STEP_DIV >> 1;
         end
         S_SMX, S_SMY, S_SMH, S_SMS, S_SMT: begin
            case (state_ff)
               S_SMX:   md_req.a = 64'(pose_x_ff) - 64'(filt_x_ff);
               S_SMY:   md_req.a = 64'(pose_y_ff) - 64'(filt_y_ff);
               S_SMH:   md_req.a = 64'(head_ff) - 64'(filt_h_ff);
               S_SMS:   md_req.a = 64'(speed_ff) - 64'(filt_s_ff);
               default: md_req.a = 64'(turn_ff) - 64'(filt_t_ff);
            endcase
            md_req.b       = $signed(32'(alpha));
            md_req.divisor = Q16_DIV;
            md_req.bias    = Q16_DIV >> 1;
         end
         S_RPX, S_RPY, S_RPH: begin
            case (state_ff)
               S_RPX:   md_req.a = 64'(filt_x_ff);
               S_RPY:   md_req.a = 64'(filt_y_ff);
               default: md_req.a = 64'(filt_h_ff);
            endcase
            md_req.b       = (state_ff == S_RPH) ? 32'sd1000 : 32'sd10;
            md_req.divisor = FIX_ONE;
            md_req.bias    = FIX_ONE >> 1;
         end
         S_RPS: begin
            // Floor division: a negative speed rounds its magnitude up.
            md_req.a       = 64'(filt_s_ff);
            md_req.b       = 32'sd1;
            md_req.divisor = SPEED_DIV;
            md_req.bias    = filt_s_ff[31] ? (SPEED_DIV - MD_DW'(1)) : '0;
         end
         default: md_req = '0;
      endcase
   end

   ddo_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         period_ff    <= 10'd20;
         gain_ff      <= 17'd22938;
         head_ff      <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         filt_x_ff    <= '0;
         filt_y_ff    <= '0;
         filt_h_ff    <= '0;
         filt_s_ff    <= '0;
         filt_t_ff    <= '0;
         elapsed_ff   <= '0;
         primed_ff    <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_TICK_PERIOD: period_ff <= csr_wdata[9:0];
               CSR_SMOOTH_GAIN: gain_ff   <= csr_wdata;
               default: ;
            endcase
         end

         // In the output state the result register is handled below.
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end

         if (md_start) begin
            issued_ff <= 1'b1;
         end

         if (is_op && md_rsp.done) begin
            issued_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  in_ff    <= req_data;
                  speed_ff <= speed_in;
                  state_ff <= S_TURN;
               end
            end
            S_TURN: begin
               if (md_rsp.done) begin
                  turn_ff  <= sat32(q);
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               if (md_rsp.done) begin
                  head_ff    <= sat32(64'(head_ff) + q);
                  elapsed_ff <= elapsed_ff + 32'(period_ff);
                  state_ff   <= S_PHASE;
               end
            end
            S_PHASE: begin
               if (md_rsp.done) begin
                  cx_ff    <= CORDIC_K_Q30;
                  cy_ff    <= '0;
                  cz_ff    <= 34'($signed(phase_fold));
                  flip_ff  <= phase[31] ^ phase[30];
                  iter_ff  <= '0;
                  state_ff <= S_CORDIC;
               end
            end
            S_CORDIC: begin
               if (!cz_ff[33]) begin
                  cx_ff <= cx_ff - cy_shift;
                  cy_ff <= cy_ff + cx_shift;
                  cz_ff <= cz_ff - atan_step;
               end else begin
                  cx_ff <= cx_ff + cy_shift;
                  cy_ff <= cy_ff - cx_shift;
                  cz_ff <= cz_ff + atan_step;
               end
               if (iter_ff == CORDIC_IW'(CORDIC_STEPS - 1)) begin
                  iter_ff  <= '0;
                  state_ff <= S_DX1;
               end else begin
                  iter_ff <= iter_ff + CORDIC_IW'(1);
               end
            end
            S_DX1: begin
               if (md_rsp.done) begin
                  tmp_ff   <= q;
                  state_ff <= S_DX2;
               end
            end
            S_DX2: begin
               if (md_rsp.done) begin
                  pose_x_ff <= sat32(64'(pose_x_ff) + q);
                  state_ff  <= S_DY1;
               end
            end
            S_DY1: begin
               if (md_rsp.done) begin
                  tmp_ff   <= q;
                  state_ff <= S_DY2;
               end
            end
            S_DY2: begin
               if (md_rsp.done) begin
                  pose_y_ff <= sat32(64'(pose_y_ff) + q);
                  if (primed_ff) begin
                     state_ff <= S_SMX;
                  end else begin
                     // First tick after reset: the smoother takes the raw values.
                     filt_x_ff <= sat32(64'(pose_y_ff) * 0 + 64'(pose_x_ff));
                     filt_y_ff <= sat32(64'(pose_y_ff) + q);
                     filt_h_ff <= head_ff;
                     filt_s_ff <= speed_ff;
                     filt_t_ff <= turn_ff;
                     primed_ff <= 1'b1;
                     state_ff  <= S_RPX;
                  end
               end
            end
            S_SMX: begin
               if (md_rsp.done) begin
                  filt_x_ff <= sat32(64'(filt_x_ff) + q);
                  state_ff  <= S_SMY;
               end
            end
            S_SMY: begin
               if (md_rsp.done) begin
                  filt_y_ff <= sat32(64'(filt_y_ff) + q);
                  state_ff  <= S_SMH;
               end
            end
            S_SMH: begin
               if (md_rsp.done) begin
                  filt_h_ff <= sat32(64'(filt_h_ff) + q);
                  state_ff  <= S_SMS;
               end
            end
            S_SMS: begin
               if (md_rsp.done) begin
                  filt_s_ff <= sat32(64'(filt_s_ff) + q);
                  state_ff  <= S_SMT;
               end
            end
            S_SMT: begin
               if (md_rsp.done) begin
                  filt_t_ff <= sat32(64'(filt_t_ff) + q);
                  state_ff  <= S_RPX;
               end
            end
            S_RPX: begin
               if (md_rsp.done) begin
                  rep_x_ff <= clamp_report(q);
                  state_ff <= S_RPY;
               end
            end
            S_RPY: begin
               if (md_rsp.done) begin
                  rep_y_ff <= clamp_report(q);
                  state_ff <= S_RPH;
               end
            end
            S_RPH: begin
               if (md_rsp.done) begin
                  rep_h_ff <= clamp_report(q);
                  state_ff <= S_RPS;
               end
            end
            S_RPS: begin
               if (md_rsp.done) begin
                  if (sb_sum < 64'sd0) begin
                     rep_sb_ff <= 8'd0;
                  end else if (sb_sum > 64'sd255) begin
                     rep_sb_ff <= 8'd255;
                  end else begin
                     rep_sb_ff <= sb_sum[7:0];
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // The result register frees up either now or when the waiting transfer ends.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff                    <= 1'b1;
                  rsp_data_ff.smooth_x_q16        <= filt_x_ff;
                  rsp_data_ff.smooth_y_q16        <= filt_y_ff;
                  rsp_data_ff.smooth_heading_q16  <= filt_h_ff;
                  rsp_data_ff.smooth_speed_q16    <= filt_s_ff;
                  rsp_data_ff.smooth_turn_q16     <= filt_t_ff;
                  rsp_data_ff.elapsed_ms          <= elapsed_ff;
                  rsp_data_ff.report_x_dm         <= rep_x_ff;
                  rsp_data_ff.report_y_dm         <= rep_y_ff;
                  rsp_data_ff.report_heading_mrad <= rep_h_ff;
                  rsp_data_ff.report_speed_byte   <= rep_sb_ff;
                  state_ff                        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A tick always starts with the turn-rate conversion.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_TURN))
      else $error("request transfer did not start a tick");

   // The shared unit only finishes work that the sequencer handed to it.
   assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> issued_ff)
      else $error("arithmetic unit finished without an issued operation");

   // The x and heading report fields stay inside their clamp range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.report_x_dm <= 16'sd30000 &&
                     rsp_data.report_x_dm >= -16'sd30000 &&
                     rsp_data.report_heading_mrad <= 16'sd30000 &&
                     rsp_data.report_heading_mrad >= -16'sd30000))
      else $error("report field outside clamp range");

   // Once primed, the smoother stays primed until reset.
   assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("smoother lost its primed state");

endmodule
`default_nettype wire

### rtl/ddo_muldiv.sv
// Bit-serial multiplier followed by a bit-serial restoring divider with rounding bias.
`default_nettype none
module ddo_muldiv
   import ddo_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  ddo_md_req_type req,
   output ddo_md_rsp_type rsp
);

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_FIN} md_state_type;

   md_state_type     state_ff;
   logic [MD_AW-1:0] mcand_ff;
   logic [MD_AW-1:0] acc_ff;
   logic [MD_AW-1:0] result_ff;
   logic [MD_BW-1:0] mplier_ff;
   logic [MD_DW-1:0] divisor_ff;
   logic [MD_DW-1:0] rem_ff;
   logic [MD_CW-1:0] cnt_ff;
   logic             neg_ff;
   logic             use_div_ff;
   logic             done_ff;

   logic [MD_AW-1:0] a_raw;
   logic [MD_AW-1:0] a_mag;
   logic [MD_BW-1:0] b_raw;
   logic [MD_BW-1:0] b_mag;
   logic [MD_DW:0]   trial;
   logic [MD_DW:0]   trial_sub;
   logic             fits;

   assign a_raw = req.a;
   assign b_raw = req.b;
   assign a_mag = a_raw[MD_AW-1] ? (~a_raw + MD_AW'(1)) : a_raw;
   assign b_mag = b_raw[MD_BW-1] ? (~b_raw + MD_BW'(1)) : b_raw;

   // One quotient bit per cycle; the dividend shifts out of acc while quotient bits shift in.
   assign trial     = {rem_ff, acc_ff[MD_AW-1]};
   assign fits      = (trial >= {1'b0, divisor_ff});
   assign trial_sub = trial - {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            MD_IDLE: begin
               if (start) begin
                  mcand_ff   <= a_mag;
                  mplier_ff  <= b_mag;
                  acc_ff     <= MD_AW'(req.bias);
                  neg_ff     <= a_raw[MD_AW-1] ^ b_raw[MD_BW-1];
                  use_div_ff <= req.use_div;
                  divisor_ff <= req.divisor;
                  rem_ff     <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= MD_MUL;
               end
            end
            MD_MUL: begin
               if (mplier_ff == '0) begin
                  state_ff <= use_div_ff ? MD_DIV : MD_FIN;
               end else begin
                  if (mplier_ff[0]) begin
                     acc_ff <= acc_ff + mcand_ff;
                  end
                  mcand_ff  <= {mcand_ff[MD_AW-2:0], 1'b0};
                  mplier_ff <= {1'b0, mplier_ff[MD_BW-1:1]};
               end
            end
            MD_DIV: begin
               rem_ff <= fits ? trial_sub[MD_DW-1:0] : trial[MD_DW-1:0];
               acc_ff <= {acc_ff[MD_AW-2:0], fits};
               cnt_ff <= cnt_ff + MD_CW'(1);
               if (cnt_ff == MD_CW'(MD_AW - 1)) begin
                  state_ff <= MD_FIN;
               end
            end
            MD_FIN: begin
               result_ff <= neg_ff ? (~acc_ff + MD_AW'(1)) : acc_ff;
               done_ff   <= 1'b1;
               state_ff  <= MD_IDLE;
            end
            default: state_ff <= MD_IDLE;
         endcase
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule
`default_nettype wire

### sim/tb_diff_drive_odometry_smoother.sv
// Self-checking testbench for the differential-drive odometry smoother.
`timescale 1ns / 1ps
`default_nettype none
module tb_diff_drive_odometry_smoother;
   import ddo_pkg::*;

   // Clock, reset and the block's ports.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ddo_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ddo_rsp_type rsp_data;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_TICK_PERIOD;
   logic [16:0] csr_wdata = '0;

   always #5 clock = ~clock;

   diff_drive_odometry_smoother dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Ticks waiting to be offered, and the poses the block should report, oldest first.
   ddo_req_type tick_queue[$];
   ddo_rsp_type pose_expected[$];
   int          error_count = 0;
   int          ticks_sent = 0;
   int          poses_seen = 0;
   int          stall_cycles_seen = 0;
   bit          want_long_hold = 0;
   bit          tick_fire = 0;

   // Shadow of the block's configuration and dead-reckoning state.
   logic [9:0]  shadow_period = 10'd20;
   logic [16:0] shadow_gain = 17'd22938;
   int          odo_x, odo_y, odo_heading;
   int          ema_x, ema_y, ema_heading, ema_speed, ema_turn;
   logic [31:0] odo_ms;
   bit          ema_primed;

   // Arctangent of 2^-i in units of 2^-32 turns, enough for the configured step count.
   localparam longint ARCTAN_STEP[24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
      64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

   // Division that rounds half away from zero; the divisor is always positive.
   function automatic longint round_div(longint n, longint d);
      longint mag;
      mag = (n < 0) ? -n : n;
      mag = (mag + d / 2) / d;
      return (n < 0) ? -mag : mag;
   endfunction

   function automatic int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic logic [15:0] report_clip(longint v);
      if (v > 30000) v = 30000;
      if (v < -30000) v = -30000;
      return v[15:0];
   endfunction

   function automatic int ema_update(int filt, int raw, longint alpha);
      return clip32(longint'(filt) + round_div((longint'(raw) - longint'(filt)) * alpha,
                                               64'sd65536));
   endfunction

   // Cosine and sine in Q30 of a phase in 2^-32 turns, rotated one step at a time.
   task automatic rotate_phase(input logic [31:0] phase, output longint c, output longint s);
      longint rx, ry, rz, sx, sy;
      bit     flip;
      rx = 64'sd652032875;
      ry = 0;
      // Phases in the left half-plane are rotated by half a turn first.
      flip = (phase[31] != phase[30]);
      if (flip) phase = phase + 32'h80000000;
      rz = longint'($signed(phase));
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         sx = ry >>> i;
         sy = rx >>> i;
         if (rz >= 0) begin
            rx -= sx; ry += sy; rz -= ARCTAN_STEP[i];
         end else begin
            rx += sx; ry -= sy; rz += ARCTAN_STEP[i];
         end
      end
      c = flip ? -rx : rx;
      s = flip ? -ry : ry;
   endtask

   // Advances the shadow state by one tick and returns the pose the block must report.
   task automatic integrate_tick(input ddo_req_type t, output ddo_rsp_type p);
      longint per, alpha, spd_l, trn_l, cs, sn, prod, sb;
      int     spd, trn;
      per = longint'(shadow_period);
      // A gain above one acts as exactly one.
      alpha = (shadow_gain > 17'd65536) ? 65536 : longint'(shadow_gain);
      spd_l = (longint'(t.left_speed_mms) + longint'(t.right_speed_mms)) * (64'sd1 << (FRAC_BITS - 1));
      spd = clip32(spd_l);
      trn_l = round_div(longint'(t.yaw_rate_dps) * 64'sd74961320, 64'sd1 << (32 - FRAC_BITS));
      trn = clip32(trn_l);
      // The heading is never wrapped, only saturated.
      odo_heading = clip32(longint'(odo_heading) + round_div(longint'(trn) * per, 1000));
      prod = longint'(odo_heading) * 64'sd683565276;
      rotate_phase(prod[FRAC_BITS +: 32], cs, sn);
      odo_x = clip32(longint'(odo_x) +
                     round_div(round_div(longint'(spd) * cs, 65536) * per, 64'sd16384000000));
      odo_y = clip32(longint'(odo_y) +
                     round_div(round_div(longint'(spd) * sn, 65536) * per, 64'sd16384000000));
      odo_ms = odo_ms + 32'(per);
      if (!ema_primed) begin
         ema_x = odo_x; ema_y = odo_y; ema_heading = odo_heading;
         ema_speed = spd; ema_turn = trn;
         ema_primed = 1;
      end else begin
         ema_x = ema_update(ema_x, odo_x, alpha);
         ema_y = ema_update(ema_y, odo_y, alpha);
         ema_heading = ema_update(ema_heading, odo_heading, alpha);
         ema_speed = ema_update(ema_speed, spd, alpha);
         ema_turn = ema_update(ema_turn, trn, alpha);
      end
      p.smooth_x_q16 = ema_x;
      p.smooth_y_q16 = ema_y;
      p.smooth_heading_q16 = ema_heading;
      p.smooth_speed_q16 = ema_speed;
      p.smooth_turn_q16 = ema_turn;
      p.elapsed_ms = odo_ms;
      p.report_x_dm = report_clip(round_div(longint'(ema_x) * 10, 64'sd1 << FRAC_BITS));
      p.report_y_dm = report_clip(round_div(longint'(ema_y) * 10, 64'sd1 << FRAC_BITS));
      p.report_heading_mrad =
         report_clip(round_div(longint'(ema_heading) * 1000, 64'sd1 << FRAC_BITS));
      // Speed byte uses a floor division, unlike the rounded report fields.
      sb = longint'(ema_speed) / (64'sd1000 << FRAC_BITS);
      if (longint'(ema_speed) % (64'sd1000 << FRAC_BITS) < 0) sb -= 1;
      sb += 128;
      if (sb < 0) sb = 0;
      if (sb > 255) sb = 255;
      p.report_speed_byte = sb[7:0];
   endtask

   task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                  $time, nm, $signed(e), e, $signed(a), a);
      end
   endtask

   // Monitor: every tick transfer updates the prediction, every pose transfer is checked.
   always @(posedge clock) begin
      ddo_rsp_type want;
      tick_fire = !reset && req_valid && req_ready;
      if (tick_fire) begin
         integrate_tick(req_data, want);
         pose_expected.push_back(want);
      end
      if (!reset && rsp_valid && !rsp_ready) stall_cycles_seen++;
      if (!reset && rsp_valid && rsp_ready) begin
         poses_seen++;
         if (pose_expected.size() == 0) begin
            error_count++;
            $display("%0t ns: pose transfer with nothing expected, got 0x%h", $time, rsp_data);
         end else begin
            want = pose_expected.pop_front();
            check_field("smooth_x_q16", want.smooth_x_q16, rsp_data.smooth_x_q16);
            check_field("smooth_y_q16", want.smooth_y_q16, rsp_data.smooth_y_q16);
            check_field("smooth_heading_q16", want.smooth_heading_q16,
                        rsp_data.smooth_heading_q16);
            check_field("smooth_speed_q16", want.smooth_speed_q16, rsp_data.smooth_speed_q16);
            check_field("smooth_turn_q16", want.smooth_turn_q16, rsp_data.smooth_turn_q16);
            check_field("elapsed_ms", want.elapsed_ms, rsp_data.elapsed_ms);
            check_field("report_x_dm", 32'($signed(want.report_x_dm)),
                        32'($signed(rsp_data.report_x_dm)));
            check_field("report_y_dm", 32'($signed(want.report_y_dm)),
                        32'($signed(rsp_data.report_y_dm)));
            check_field("report_heading_mrad", 32'($signed(want.report_heading_mrad)),
                        32'($signed(rsp_data.report_heading_mrad)));
            check_field("report_speed_byte", 32'(want.report_speed_byte),
                        32'(rsp_data.report_speed_byte));
         end
      end
   end

   // Driver: offers ticks in bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset && (!req_valid || tick_fire)) begin
         if (gap_left > 0 || tick_queue.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_data <= tick_queue.pop_front();
            req_valid <= 1'b1;
            ticks_sent++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 6);
               // Some bursts run back to back, others leave a random gap.
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 2000);
            end
         end
      end
   end

   // Receiver: random short stalls, stall-free stretches, and an occasional long hold-off
   // during which the block runs out of room and stops taking ticks.
   int hold_left = 0;
   int free_left = 0;
   always @(negedge clock) begin
      if (want_long_hold) begin
         want_long_hold = 0;
         hold_left = 8000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (free_left > 0) begin
         free_left--;
         rsp_ready <= 1'b1;
      end else begin
         case ($urandom_range(0, 3))
            0: hold_left = $urandom_range(1, 40);
            1: free_left = $urandom_range(50, 3000);
            default: free_left = $urandom_range(0, 5);
         endcase
         rsp_ready <= (hold_left == 0);
      end
   end

   task automatic write_reg(input logic idx, input logic [16:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_TICK_PERIOD) shadow_period = val[9:0];
      else shadow_gain = val;
   endtask

   // The sender pauses here until every pose has come back; registers change only then.
   task automatic drain_and_settle();
      wait (tick_queue.size() == 0 && !req_valid && pose_expected.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic push_tick(input logic [15:0] l, input logic [15:0] r, input logic [11:0] y);
      ddo_req_type t;
      t.left_speed_mms = l;
      t.right_speed_mms = r;
      t.yaw_rate_dps = y;
      tick_queue.push_back(t);
   endtask

   task automatic push_random_ticks(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0)
            push_tick($urandom(), $urandom(), $urandom());
         else
            // Plausible driving: modest wheel speeds and rates within the gyro range.
            push_tick(16'($signed($urandom_range(0, 8000)) - 4000),
                      16'($signed($urandom_range(0, 8000)) - 4000),
                      12'($signed($urandom_range(0, 4000)) - 2000));
      end
   endtask

   initial begin
      odo_x = 0; odo_y = 0; odo_heading = 0; odo_ms = '0;
      ema_x = 0; ema_y = 0; ema_heading = 0; ema_speed = 0; ema_turn = 0;
      ema_primed = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks at the reset settings; the first one loads the smoother directly.
      push_tick(16'sd1000, 16'sd1000, 12'sd0);
      push_tick(16'sh7FFF, 16'sh7FFF, 12'sd0);
      push_tick(16'sh8000, 16'sh8000, 12'sd0);
      push_tick(16'sh7FFF, 16'sh8000, 12'sd2000);
      push_tick(16'sh8000, 16'sh7FFF, -12'sd2000);
      push_tick(16'sd0, 16'sd0, 12'sh7FF);
      push_tick(16'sd0, 16'sd0, 12'sh800);
      push_tick(16'sd500, -16'sd500, 12'sd90);
      push_tick(-16'sd1, 16'sd0, -12'sd1);
      push_tick(16'sd2000, 16'sd2000, 12'sd0);
      drain_and_settle();

      // Zero period freezes the pose and counter; a gain of exactly one.
      write_reg(CSR_TICK_PERIOD, 17'd0);
      write_reg(CSR_SMOOTH_GAIN, 17'd65536);
      push_tick(16'sd3000, 16'sd3000, 12'sd500);
      push_tick(-16'sd3000, 16'sd1000, -12'sd500);
      drain_and_settle();

      // Period beyond the nominal range and a gain above one.
      write_reg(CSR_TICK_PERIOD, 17'd1023);
      write_reg(CSR_SMOOTH_GAIN, 17'h1FFFF);
      push_tick(16'sd1500, 16'sd1500, 12'sd1000);
      push_tick(16'sh7FFF, 16'sh7FFF, 12'sh7FF);
      drain_and_settle();

      // Random phases at extreme and ordinary settings.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin write_reg(CSR_TICK_PERIOD, 17'd1); write_reg(CSR_SMOOTH_GAIN, 17'd0); end
            1: begin write_reg(CSR_TICK_PERIOD, 17'd1000);
                     write_reg(CSR_SMOOTH_GAIN, 17'd65535); end
            2: begin write_reg(CSR_TICK_PERIOD, 17'd20);
                     write_reg(CSR_SMOOTH_GAIN, 17'd22938); end
            default: begin
               write_reg(CSR_TICK_PERIOD, 17'($urandom_range(0, 1023)));
               write_reg(CSR_SMOOTH_GAIN, 17'($urandom_range(0, 131071)));
            end
         endcase
         push_random_ticks(50);
         if (ph == 2) want_long_hold = 1;
         drain_and_settle();
      end

      // Long full-speed run: the x report clamps.
      write_reg(CSR_TICK_PERIOD, 17'd1023);
      write_reg(CSR_SMOOTH_GAIN, 17'd65536);
      for (int i = 0; i < 520; i++)
         push_tick(16'($urandom_range(30000, 32767)), 16'($urandom_range(30000, 32767)),
                   12'sd0);
      drain_and_settle();

      repeat (2000) @(posedge clock);
      $display("Covered %0d ticks and %0d poses across period 0..1023 and gain 0..2,",
               ticks_sent, poses_seen);
      $display("with %0d receiver stall cycles and a saturating full-speed run.",
               stall_cycles_seen);
      if (error_count == 0 && pose_expected.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #300ms;
      $display("Timeout with %0d poses still expected", pose_expected.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire
